// ===== sv/delayed_xor_lattice_bit_source_macros.svh =====
// assertion macros used by the checker file
`ifndef DELAYED_XOR_LATTICE_BIT_SOURCE_MACROS_SVH
`define DELAYED_XOR_LATTICE_BIT_SOURCE_MACROS_SVH

// concurrent assertion on clk_i, off while rst_ni is low
`define DXLBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form built on the one above
`define DXLBS_ASSERT_IMP(lbl, pre, post, msg) \
  `DXLBS_ASSERT(lbl, (pre) |-> (post), msg)

`endif

// ===== sv/dxlbs_pkg.sv =====
// ----------------------------------------------------------------------------
// dxlbs_pkg
// Shared constants, types and command codes of the XOR lattice bit source.
// ----------------------------------------------------------------------------
package dxlbs_pkg;

  localparam int NEURON_COUNT        = 1024;
  localparam int SYNAPSES_PER_NEURON = 12;
  localparam int FRAME_SIZE          = 16384;
  localparam int BITS_PER_TICK       = 125;
  localparam int SPIKE_THRESHOLD     = 127;
  localparam int TAP_SPACING         = 256;
  localparam int TAP_COUNT           = 4;

  localparam int NEURON_AW = $clog2(NEURON_COUNT);
  localparam int FRAME_AW  = $clog2(FRAME_SIZE);
  localparam int LIMIT_W   = 20;
  localparam int WORD_W    = 64;
  localparam int ACC_W     = 128;
  localparam int ACC_IW    = $clog2(ACC_W);
  localparam int COUNT_W   = 8;
  localparam int BITCNT_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd1000000;

  // input commands
  typedef enum logic [2:0] {
    CMD_LOAD_SYN  = 3'd0,
    CMD_LOAD_NRN  = 3'd1,
    CMD_LOAD_SPK  = 3'd2,
    CMD_TICK      = 3'd3,
    CMD_RESTART   = 3'd4
  } cmd_e;

  // one synapse entry
  typedef struct packed {
    logic [13:0] src;
    logic [7:0]  delay;
    logic [7:0]  timer;
    logic        active;
  } syn_t;

  localparam int SYN_W = $bits(syn_t);

  // controller to datapath commands
  typedef struct packed {
    logic                 syn_we;
    logic                 nrn_we;
    logic                 spk_we;
    logic                 rd_en;
    logic [NEURON_AW-1:0] rd_addr;
    logic                 acc_clr;
    logic                 word_hi;
    logic [BITCNT_W-1:0]  word_bits;
  } ctrl_cmd_t;

endpackage

// ===== sv/dxlbs_ram.sv =====
// ----------------------------------------------------------------------------
// dxlbs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dxlbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dxlbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dxlbs_ctrl
// Command decode, tick sequencer and bit budget of the lattice bit source.
// ----------------------------------------------------------------------------
module dxlbs_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     in_cmd_i,
  input  logic [9:0]                     in_neuron_i,
  input  logic [3:0]                     in_slot_i,
  input  logic [13:0]                    in_frame_i,
  input  logic                           cfg_we_i,
  input  logic [dxlbs_pkg::LIMIT_W-1:0]  cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_last_o,
  output dxlbs_pkg::ctrl_cmd_t           cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SWEEP = 5'b00010,
    S_DRAIN = 5'b00100,
    S_OUT0  = 5'b01000,
    S_OUT1  = 5'b10000
  } state_e;

  state_e                              state_q, state_d;
  logic [dxlbs_pkg::NEURON_AW-1:0]     n_q, n_d;
  logic                                drain_q, drain_d;
  logic [dxlbs_pkg::LIMIT_W-1:0]       limit_q, emitted_q, emitted_d;
  logic [dxlbs_pkg::COUNT_W-1:0]       count_q, count_d;
  logic [dxlbs_pkg::LIMIT_W-1:0]       room;
  logic [dxlbs_pkg::COUNT_W-1:0]       count_new;
  logic                                accept, nrn_ok, slot_ok, frame_ok, two_words;

  assign accept    = in_valid_i && in_ready_o;
  assign nrn_ok    = 32'(in_neuron_i) < dxlbs_pkg::NEURON_COUNT;
  assign slot_ok   = 32'(in_slot_i) < dxlbs_pkg::SYNAPSES_PER_NEURON;
  assign frame_ok  = 32'(in_frame_i) < dxlbs_pkg::FRAME_SIZE;
  assign room      = limit_q - emitted_q;
  assign count_new = (room < dxlbs_pkg::LIMIT_W'(dxlbs_pkg::BITS_PER_TICK)) ?
                     dxlbs_pkg::COUNT_W'(room) :
                     dxlbs_pkg::COUNT_W'(dxlbs_pkg::BITS_PER_TICK);
  assign two_words = count_q > dxlbs_pkg::COUNT_W'(dxlbs_pkg::WORD_W);

  // next state and sweep control
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    drain_d   = drain_q;
    emitted_d = emitted_q;
    count_d   = count_q;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            dxlbs_pkg::CMD_LOAD_SYN: cmd_o.syn_we = nrn_ok && slot_ok;
            dxlbs_pkg::CMD_LOAD_NRN: cmd_o.nrn_we = nrn_ok;
            dxlbs_pkg::CMD_LOAD_SPK: cmd_o.spk_we = frame_ok;
            dxlbs_pkg::CMD_RESTART:  emitted_d = '0;
            dxlbs_pkg::CMD_TICK: begin
              if (emitted_q < limit_q) begin
                cmd_o.acc_clr = 1'b1;
                count_d       = count_new;
                emitted_d     = emitted_q + dxlbs_pkg::LIMIT_W'(count_new);
                n_d           = '0;
                state_d       = S_SWEEP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = n_q;
        n_d           = n_q + 1'b1;
        if (n_q == dxlbs_pkg::NEURON_AW'(dxlbs_pkg::NEURON_COUNT - 1)) begin
          drain_d = 1'b0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = S_OUT0;
        end
      end
      S_OUT0: begin
        cmd_o.word_bits = two_words ? dxlbs_pkg::BITCNT_W'(dxlbs_pkg::WORD_W) :
                                      dxlbs_pkg::BITCNT_W'(count_q);
        if (out_ready_i) begin
          state_d = two_words ? S_OUT1 : S_IDLE;
        end
      end
      S_OUT1: begin
        cmd_o.word_hi   = 1'b1;
        cmd_o.word_bits = dxlbs_pkg::BITCNT_W'(count_q - dxlbs_pkg::COUNT_W'(dxlbs_pkg::WORD_W));
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      n_q       <= '0;
      drain_q   <= 1'b0;
      emitted_q <= '0;
      count_q   <= '0;
      limit_q   <= dxlbs_pkg::LIMIT_RESET;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      drain_q   <= drain_d;
      emitted_q <= emitted_d;
      count_q   <= count_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT0) || (state_q == S_OUT1);
  assign out_last_o  = (state_q == S_OUT1) || !two_words;

endmodule

// ===== sv/dxlbs_datapath.sv =====
// ----------------------------------------------------------------------------
// dxlbs_datapath
// Synapse, neuron and spike memories, the three-stage neuron update pipe and
// the tap accumulator that forms the output bits.
// ----------------------------------------------------------------------------
module dxlbs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dxlbs_pkg::ctrl_cmd_t                 cmd_i,
  input  logic [9:0]                           neuron_index_i,
  input  logic [3:0]                           synapse_slot_i,
  input  logic [13:0]                          source_index_i,
  input  logic [7:0]                           delay_value_i,
  input  logic [7:0]                           timer_value_i,
  input  logic                                 active_value_i,
  input  logic                                 state_value_i,
  input  logic [13:0]                          frame_index_i,
  input  logic [7:0]                           frame_byte_i,
  output logic [dxlbs_pkg::WORD_W-1:0]         word_o
);

  localparam int SPN = dxlbs_pkg::SYNAPSES_PER_NEURON;
  localparam int NAW = dxlbs_pkg::NEURON_AW;
  localparam int NW  = NAW + 1;

  dxlbs_pkg::syn_t  row1 [SPN];
  dxlbs_pkg::syn_t  row2_q [SPN];
  dxlbs_pkg::syn_t  row_new [SPN];
  dxlbs_pkg::syn_t  load_entry;
  logic [SPN-1:0]   spike2;
  logic             valid1_q, valid2_q;
  logic [NAW-1:0]   n1_q, n2_q;
  logic             nrn_old, nrn_new, flux;
  logic [dxlbs_pkg::ACC_W-1:0] acc_q, toggle;
  logic [NAW-1:0]   nrn_waddr;
  logic             nrn_wdata, nrn_we;
  logic [NAW-1:0]   syn_waddr;
  logic             spike_bit;
  logic [dxlbs_pkg::WORD_W-1:0] raw_word, mask;

  assign load_entry = '{src: source_index_i, delay: delay_value_i,
                        timer: timer_value_i, active: active_value_i};
  assign spike_bit  = 32'(frame_byte_i) > dxlbs_pkg::SPIKE_THRESHOLD;
  assign syn_waddr  = valid2_q ? n2_q : NAW'(neuron_index_i);

  // per-slot synapse memory and per-slot copy of the spike frame
  for (genvar s = 0; s < SPN; s++) begin : g_slot
    logic syn_we;
    logic spk_rd;
    assign syn_we = valid2_q ||
                    (cmd_i.syn_we && (32'(synapse_slot_i) == s));

    dxlbs_ram #(.WIDTH(dxlbs_pkg::SYN_W), .DEPTH(dxlbs_pkg::NEURON_COUNT)) u_syn (
      .clk_i   (clk_i),
      .we_i    (syn_we),
      .waddr_i (syn_waddr),
      .wdata_i (valid2_q ? row_new[s] : load_entry),
      .raddr_i (cmd_i.rd_addr),
      .rdata_o (row1[s])
    );

    dxlbs_ram #(.WIDTH(1), .DEPTH(dxlbs_pkg::FRAME_SIZE)) u_spk (
      .clk_i   (clk_i),
      .we_i    (cmd_i.spk_we),
      .waddr_i (dxlbs_pkg::FRAME_AW'(frame_index_i)),
      .wdata_i (spike_bit),
      .raddr_i (dxlbs_pkg::FRAME_AW'(row1[s].src)),
      .rdata_o (spk_rd)
    );

    // a source beyond the frame never spikes
    assign spike2[s] = spk_rd && (32'(row2_q[s].src) < dxlbs_pkg::FRAME_SIZE);
  end

  // neuron state memory
  assign nrn_we    = valid2_q || cmd_i.nrn_we;
  assign nrn_waddr = valid2_q ? n2_q : NAW'(neuron_index_i);
  assign nrn_wdata = valid2_q ? nrn_new : state_value_i;

  dxlbs_ram #(.WIDTH(1), .DEPTH(dxlbs_pkg::NEURON_COUNT)) u_nrn (
    .clk_i   (clk_i),
    .we_i    (nrn_we),
    .waddr_i (nrn_waddr),
    .wdata_i (nrn_wdata),
    .raddr_i (n1_q),
    .rdata_o (nrn_old)
  );

  // synapse update of one neuron
  always_comb begin
    logic act, fire;
    flux = 1'b0;
    for (int s = 0; s < SPN; s++) begin
      act  = row2_q[s].active || spike2[s];
      fire = act && (row2_q[s].timer >= row2_q[s].delay);
      row_new[s] = row2_q[s];
      if (fire) begin
        row_new[s].timer  = '0;
        row_new[s].active = 1'b0;
        flux = ~flux;
      end else begin
        row_new[s].active = act;
        if (act) begin
          row_new[s].timer = row2_q[s].timer + 8'd1;
        end
      end
    end
    nrn_new = nrn_old ^ flux;
  end

  // tap positions hit by this neuron, modulo the neuron count
  always_comb begin
    logic [NW-1:0] p;
    toggle = '0;
    for (int k = 0; k < dxlbs_pkg::TAP_COUNT; k++) begin
      p = {1'b0, n2_q} + NW'(dxlbs_pkg::NEURON_COUNT -
          ((k * dxlbs_pkg::TAP_SPACING) % dxlbs_pkg::NEURON_COUNT));
      if (p >= NW'(dxlbs_pkg::NEURON_COUNT)) begin
        p = p - NW'(dxlbs_pkg::NEURON_COUNT);
      end
      if (32'(p) < dxlbs_pkg::BITS_PER_TICK) begin
        toggle[dxlbs_pkg::ACC_IW'(p)] = ~toggle[dxlbs_pkg::ACC_IW'(p)];
      end
    end
  end

  // pipe control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= cmd_i.rd_en;
      valid2_q <= valid1_q;
    end
  end

  // pipe payload and tap accumulator
  always_ff @(posedge clk_i) begin
    n1_q   <= cmd_i.rd_addr;
    n2_q   <= n1_q;
    row2_q <= row1;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (valid2_q && nrn_new) begin
      acc_q <= acc_q ^ toggle;
    end
  end

  // output word, bits past the count forced to zero
  assign raw_word = cmd_i.word_hi ? acc_q[dxlbs_pkg::ACC_W-1:dxlbs_pkg::WORD_W] :
                                    acc_q[dxlbs_pkg::WORD_W-1:0];
  assign mask = (cmd_i.word_bits >= dxlbs_pkg::BITCNT_W'(dxlbs_pkg::WORD_W)) ? '1 :
                ((dxlbs_pkg::WORD_W'(1) << cmd_i.word_bits) - 1'b1);
  assign word_o = raw_word & mask;

endmodule

// ===== sv/delayed_xor_lattice_bit_source.sv =====
// ----------------------------------------------------------------------------
// delayed_xor_lattice_bit_source
// Lattice of one-bit neurons with delayed synapses, emitting XOR tap bits.
// ----------------------------------------------------------------------------
// Load commands (synapse, neuron state, spike byte, restart) are accepted in
// the idle state. A tick walks the neurons through a three-stage pipe fed by
// the per-slot synapse memories, one neuron a cycle, then drains the pipe and
// gives one or two output beats. A tick at the bit limit gives no beat. Input
// is taken only while no tick is in progress. Every synapse, neuron and spike
// entry must be loaded before the first tick.
module delayed_xor_lattice_bit_source (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // neuron_index, synapse_slot, source_index, delay_value, timer_value,
  // active_value, state_value, frame_index, frame_byte, zero pad
  input  logic [71:0] s_axis_tdata,
  // command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bit_word, bit_count, zero pad
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i
);

  dxlbs_pkg::ctrl_cmd_t             cmd;
  logic [dxlbs_pkg::WORD_W-1:0]     word;

  assign cfg_ready_o = 1'b1;

  dxlbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_neuron_i (s_axis_tdata[9:0]),
    .in_slot_i   (s_axis_tdata[13:10]),
    .in_frame_i  (s_axis_tdata[59:46]),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .cmd_o       (cmd)
  );

  dxlbs_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .neuron_index_i (s_axis_tdata[9:0]),
    .synapse_slot_i (s_axis_tdata[13:10]),
    .source_index_i (s_axis_tdata[27:14]),
    .delay_value_i  (s_axis_tdata[35:28]),
    .timer_value_i  (s_axis_tdata[43:36]),
    .active_value_i (s_axis_tdata[44]),
    .state_value_i  (s_axis_tdata[45]),
    .frame_index_i  (s_axis_tdata[59:46]),
    .frame_byte_i   (s_axis_tdata[67:60]),
    .word_o         (word)
  );

  // output beat
  assign m_axis_tdata = {1'b0, cmd.word_bits, word};

endmodule

// ===== sv/dxlbs_checker.sv =====
// ----------------------------------------------------------------------------
// dxlbs_checker
// Port-level checks of the lattice bit source, bound to the top level.
// ----------------------------------------------------------------------------
`include "delayed_xor_lattice_bit_source_macros.svh"

module dxlbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [6:0] out_count;
  logic       out_beat;

  assign out_count = m_axis_tdata[70:64];
  assign out_beat  = m_axis_tvalid && m_axis_tready;

  // a stalled result beat stays up
  `DXLBS_ASSERT_IMP(a_out_hold, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid, "beat dropped")
  // input is never taken while a result waits
  `DXLBS_ASSERT(a_no_overlap, !(m_axis_tvalid && s_axis_tready), "input taken during output")
  // a first word that is not the last one is full
  `DXLBS_ASSERT_IMP(a_full_first, m_axis_tvalid && !m_axis_tlast, out_count == 7'd64, "short word")
  // every beat carries at least one bit, at most a word
  `DXLBS_ASSERT_IMP(a_count_range, m_axis_tvalid, out_count != 7'd0 && out_count <= 7'd64, "count")
  // the final beat of a tick returns the block to idle
  `DXLBS_ASSERT_IMP(a_idle_after, out_beat && m_axis_tlast, ##1 (s_axis_tready && !m_axis_tvalid), "busy")

endmodule

bind delayed_xor_lattice_bit_source dxlbs_checker u_dxlbs_checker (.*);
